[rtl/radix2_fixed_point_complex_ifft_assert.svh]
// Assertion macros for the radix-2 inverse FFT block.
`ifndef RADIX2_FIXED_POINT_COMPLEX_IFFT_ASSERT_SVH
`define RADIX2_FIXED_POINT_COMPLEX_IFFT_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define R2F_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define R2F_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[rtl/r2fft_pkg.sv]
// Shared types, constants and twiddle ROM of the radix-2 inverse FFT block.
package r2fft_pkg;
    localparam int LOG_MAX_POINTS_DEF = 6;
    localparam logic [3:0] LOG_POINTS_RST = 4'd6;
    localparam logic PREC_RST = 1'b1;
    localparam logic [15:0] THR_ONE = 16'd13573;
    localparam logic [15:0] THR_TWO = 16'd27146;
    localparam logic CFG_LOG_POINTS = 1'b0;
    localparam logic CFG_PRECISION = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD, ST_SCAN, ST_BFLY, ST_DRAIN, ST_OUT
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_wr;
        logic scan_rd;
        logic scan_clr;
        logic bf_rd;
        logic out_rd;
        logic set_shift;
        logic clr_exp;
    } t_cmd;

    // Quarter-wave sine table, round(32767*sin(2*pi*j/1024)), j = 0..256.
    function automatic logic [15:0] sine_quarter(input logic [8:0] j);
        real x;
        begin
            x = 32767.0 * $sin(2.0 * 3.14159265358979323846 * real'(j) / 1024.0);
            sine_quarter = 16'(int'(x));
        end
    endfunction

    // Full sine over a 1024 step circle.
    function automatic logic signed [16:0] sine_rom(input logic [9:0] t);
        logic signed [16:0] v;
        begin
            if (t <= 10'd256) v = 17'(signed'({1'b0, sine_quarter(9'(t))}));
            else if (t <= 10'd512) v = 17'(signed'({1'b0, sine_quarter(9'(10'd512 - t))}));
            else if (t <= 10'd768) v = -17'(signed'({1'b0, sine_quarter(9'(t - 10'd512))}));
            else v = -17'(signed'({1'b0, sine_quarter(9'(11'd1024 - {1'b0, t}))}));
            sine_rom = v;
        end
    endfunction
endpackage

[rtl/r2fft_ctrl.sv]
// Sequencer for loading, scanning, butterfly stages and unloading.
module r2fft_ctrl import r2fft_pkg::*; #(
    parameter int LOG_MAX_POINTS = LOG_MAX_POINTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_out_stall,
    input  logic                      i_out_busy,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [3:0]                i_cfg_data,
    output t_cmd                      o_cmd,
    output logic [LOG_MAX_POINTS-1:0] o_addr_a,
    output logic [LOG_MAX_POINTS-1:0] o_addr_b,
    output logic [LOG_MAX_POINTS-1:0] o_tw,
    output logic [3:0]                o_stage,
    output logic                      o_last,
    output logic                      o_prec
);
    localparam int CW = LOG_MAX_POINTS + 1;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [3:0] r_stage, n_stage;
    logic [3:0] r_logp;
    logic r_prec;
    logic [3:0] w_st;
    logic [CW-1:0] w_n;
    logic [CW-1:0] w_mask;
    logic [CW-1:0] w_lo, w_hi, w_i;
    logic [2:0] r_drain, n_drain;

    assign w_st = (r_logp > 4'(LOG_MAX_POINTS)) ? 4'(LOG_MAX_POINTS) : r_logp;
    assign w_n = CW'(1) << w_st;
    assign w_mask = (CW'(1) << r_stage) - CW'(1);
    // Butterfly index: insert a zero bit at position stage into the counter.
    assign w_lo = r_cnt & w_mask;
    assign w_hi = (r_cnt & ~w_mask) << 1;
    assign w_i = w_hi | w_lo;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_logp <= LOG_POINTS_RST;
            r_prec <= PREC_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_LOG_POINTS) r_logp <= i_cfg_data;
            else r_prec <= i_cfg_data[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt <= '0;
            r_stage <= '0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_stage <= n_stage;
            r_drain <= n_drain;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_stage = r_stage;
        n_drain = r_drain;
        o_cmd = '0;
        o_stall = 1'b1;
        o_addr_a = r_cnt[LOG_MAX_POINTS-1:0];
        o_addr_b = r_cnt[LOG_MAX_POINTS-1:0];
        o_tw = LOG_MAX_POINTS'(w_lo << (LOG_MAX_POINTS - 1 - int'(r_stage)));
        o_last = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_stall = i_out_busy;
                if (i_cfg_we && i_cfg_idx == CFG_LOG_POINTS) n_cnt = '0;
                else if (i_valid && !i_out_busy) begin
                    o_cmd.load_wr = 1'b1;
                    if (r_cnt + CW'(1) >= w_n) begin
                        n_cnt = '0;
                        n_stage = '0;
                        o_cmd.clr_exp = 1'b1;
                        n_state = (w_st == 4'd0) ? ST_OUT : ST_SCAN;
                        o_cmd.scan_clr = 1'b1;
                    end else begin
                        n_cnt = r_cnt + CW'(1);
                    end
                end
            end
            // Peak magnitude scan, one word per cycle, plus read and compare slots.
            ST_SCAN: begin
                o_cmd.scan_rd = (r_cnt < w_n);
                if (r_cnt == w_n + CW'(1)) begin
                    o_cmd.set_shift = 1'b1;
                    n_cnt = '0;
                    n_state = ST_BFLY;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            // One butterfly per cycle through a three-deep pipeline.
            ST_BFLY: begin
                o_cmd.bf_rd = 1'b1;
                o_addr_a = w_i[LOG_MAX_POINTS-1:0];
                o_addr_b = LOG_MAX_POINTS'(w_i | (CW'(1) << r_stage));
                if (r_cnt + CW'(1) >= (w_n >> 1)) begin
                    n_cnt = '0;
                    n_drain = 3'd3;
                    n_state = ST_DRAIN;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            ST_DRAIN: begin
                if (r_drain == 3'd0) begin
                    if (r_stage + 4'd1 >= w_st) begin
                        n_state = ST_OUT;
                    end else begin
                        n_stage = r_stage + 4'd1;
                        n_state = ST_SCAN;
                        o_cmd.scan_clr = 1'b1;
                    end
                end else begin
                    n_drain = r_drain - 3'd1;
                end
            end
            ST_OUT: begin
                o_last = (r_cnt + CW'(1) >= w_n);
                if (!i_out_busy) begin
                    o_cmd.out_rd = 1'b1;
                    if (o_last) begin
                        n_cnt = '0;
                        n_state = ST_LOAD;
                    end else begin
                        n_cnt = r_cnt + CW'(1);
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    assign o_stage = r_stage;
    assign o_prec = r_prec;
endmodule

[rtl/r2fft_dp.sv]
// Sample memory, peak scan, butterfly arithmetic and output register.
module r2fft_dp import r2fft_pkg::*; #(
    parameter int LOG_MAX_POINTS = LOG_MAX_POINTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    input  logic [LOG_MAX_POINTS-1:0] i_addr_a,
    input  logic [LOG_MAX_POINTS-1:0] i_addr_b,
    input  logic [LOG_MAX_POINTS-1:0] i_tw,
    input  logic                      i_last,
    input  logic                      i_prec,
    input  logic signed [15:0]        i_sample_re,
    input  logic signed [15:0]        i_sample_im,
    input  logic                      i_out_stall,
    output logic                      o_busy,
    output logic                      o_valid,
    output logic signed [15:0]        o_out_re,
    output logic signed [15:0]        o_out_im,
    output logic [4:0]                o_block_exponent,
    output logic                      o_last_flag
);
    localparam int DEPTH = 1 << LOG_MAX_POINTS;

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rd_a, r_rd_b;
    logic [LOG_MAX_POINTS-1:0] r_wa1, r_wb1, r_wa2, r_wb2;
    logic r_v1, r_v2, r_scan_v;
    logic [15:0] r_peak;
    logic [1:0] r_sh;
    logic [4:0] r_exp;
    logic signed [16:0] r_wr, r_wi;
    logic signed [33:0] r_pr, r_pi;
    logic signed [15:0] r_qr, r_qi;
    logic [31:0] w_wa, w_wb;
    logic [15:0] w_abs_r, w_abs_i, w_max;
    logic signed [16:0] w_xr, w_xi;
    logic signed [34:0] w_tr, w_ti;
    logic signed [50:0] w_ar, w_br, w_ai, w_bi, w_rnd;
    logic [5:0] w_shr;
    logic r_ovalid, r_olast;
    logic [31:0] r_odata;

    // Sample memory with registered read ports and one write per port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) r_mem[i_addr_a] <= {i_sample_im, i_sample_re};
        if (r_v2) begin
            r_mem[r_wa2] <= w_wa;
            r_mem[r_wb2] <= w_wb;
        end
        r_rd_a <= r_mem[i_addr_a];
        r_rd_b <= r_mem[i_addr_b];
    end

    // Peak magnitude scan.
    assign w_abs_r = r_rd_a[15] ? 16'(-r_rd_a[15:0]) : r_rd_a[15:0];
    assign w_abs_i = r_rd_a[31] ? 16'(-r_rd_a[31:16]) : r_rd_a[31:16];
    assign w_max = (w_abs_r > w_abs_i) ? w_abs_r : w_abs_i;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_v <= 1'b0;
            r_exp <= '0;
        end else begin
            r_scan_v <= i_cmd.scan_rd;
            if (i_cmd.clr_exp) r_exp <= '0;
            else if (i_cmd.set_shift)
                r_exp <= r_exp + 5'((r_peak > THR_ONE) ? ((r_peak > THR_TWO) ? 2 : 1) : 0);
        end
        if (i_cmd.scan_clr) r_peak <= '0;
        else if (r_scan_v && w_max > r_peak) r_peak <= w_max;
        if (i_cmd.set_shift)
            r_sh <= (r_peak > THR_ONE) ? ((r_peak > THR_TWO) ? 2'd2 : 2'd1) : 2'd0;
    end

    // Stage one: read; stage two: products; stage three: sums and write.
    assign w_xr = 17'(signed'(r_rd_b[15:0]));
    assign w_xi = 17'(signed'(r_rd_b[31:16]));
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.bf_rd;
            r_v2 <= r_v1;
        end
        r_wa1 <= i_addr_a;
        r_wb1 <= i_addr_b;
        r_wa2 <= r_wa1;
        r_wb2 <= r_wb1;
        r_wr <= sine_rom((10'(i_tw) << (10 - LOG_MAX_POINTS)) + 10'd256);
        r_wi <= sine_rom(10'(i_tw) << (10 - LOG_MAX_POINTS));
        r_pr <= 34'(r_wr * w_xr) - 34'(r_wi * w_xi);
        r_pi <= 34'(r_wr * w_xi) + 34'(r_wi * w_xr);
        r_qr <= signed'(r_rd_a[15:0]);
        r_qi <= signed'(r_rd_a[31:16]);
    end

    always_comb begin
        if (i_prec) begin
            w_tr = (35'(r_pr) + 35'sd1) >>> 1;
            w_ti = (35'(r_pi) + 35'sd1) >>> 1;
            w_rnd = 51'sd8192 <<< r_sh;
            w_shr = 6'(r_sh) + 6'd14;
            w_ar = (51'(r_qr) <<< 14) + 51'(w_tr) + w_rnd;
            w_br = (51'(r_qr) <<< 14) - 51'(w_tr) + w_rnd;
            w_ai = (51'(r_qi) <<< 14) + 51'(w_ti) + w_rnd;
            w_bi = (51'(r_qi) <<< 14) - 51'(w_ti) + w_rnd;
        end else begin
            w_tr = 35'(r_pr) >>> 15;
            w_ti = 35'(r_pi) >>> 15;
            w_rnd = '0;
            w_shr = 6'(r_sh);
            w_ar = 51'(r_qr) + 51'(w_tr);
            w_br = 51'(r_qr) - 51'(w_tr);
            w_ai = 51'(r_qi) + 51'(w_ti);
            w_bi = 51'(r_qi) - 51'(w_ti);
        end
        w_wa = {16'(w_ai >>> w_shr), 16'(w_ar >>> w_shr)};
        w_wb = {16'(w_bi >>> w_shr), 16'(w_br >>> w_shr)};
    end

    // Output register fed from the memory read port in the cycle after the read.
    logic r_rd_pend, r_rd_last;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.out_rd;
            if (r_rd_pend) r_ovalid <= 1'b1;
            else if (!i_out_stall) r_ovalid <= 1'b0;
        end
        r_rd_last <= i_last;
        if (r_rd_pend) begin
            r_odata <= r_rd_a;
            r_olast <= r_rd_last;
        end
    end

    // Busy while a read is in flight or a held result is not taken this cycle.
    assign o_busy = r_rd_pend || (r_ovalid && i_out_stall);
    assign o_valid = r_ovalid;
    assign o_out_re = signed'(r_odata[15:0]);
    assign o_out_im = signed'(r_odata[31:16]);
    assign o_block_exponent = r_exp;
    assign o_last_flag = r_olast;
endmodule

[rtl/radix2_fixed_point_complex_ifft.sv]
// Top level of the block floating point radix-2 inverse FFT.
// Load accepts one item per cycle while the output side is not busy; each of the
// S stages scans for the peak, then runs its butterflies on the single butterfly unit.
// Results leave one at a time: no new read starts while one is in flight or held stalled.
// Synchronous active-low reset returns to loading with an empty frame.
// Sample memory holds no reset value; every entry is written before use.
module radix2_fixed_point_complex_ifft import r2fft_pkg::*; #(
    parameter int LOG_MAX_POINTS = LOG_MAX_POINTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_sample_re,
    input  logic signed [15:0] i_sample_im,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_out_re,
    output logic signed [15:0] o_out_im,
    output logic [4:0]         o_block_exponent,
    output logic               o_last_flag,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [3:0]         i_cfg_data
);
    `include "radix2_fixed_point_complex_ifft_assert.svh"

    t_cmd w_cmd;
    logic [LOG_MAX_POINTS-1:0] w_addr_a, w_addr_b, w_tw;
    logic [3:0] w_stage;
    logic w_last, w_prec, w_busy;

    r2fft_ctrl #(.LOG_MAX_POINTS(LOG_MAX_POINTS)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_out_stall(i_stall), .i_out_busy(w_busy),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_cmd(w_cmd), .o_addr_a(w_addr_a), .o_addr_b(w_addr_b), .o_tw(w_tw),
        .o_stage(w_stage), .o_last(w_last), .o_prec(w_prec)
    );

    r2fft_dp #(.LOG_MAX_POINTS(LOG_MAX_POINTS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_addr_a(w_addr_a), .i_addr_b(w_addr_b),
        .i_tw(w_tw), .i_last(w_last), .i_prec(w_prec),
        .i_sample_re, .i_sample_im, .i_out_stall(i_stall), .o_busy(w_busy),
        .o_valid, .o_out_re, .o_out_im, .o_block_exponent, .o_last_flag
    );

    `R2F_ASSERT_IMP(a_stage_range, i_clk, i_rst_n, 1'b1, w_stage <= 4'(LOG_MAX_POINTS))
    `R2F_ASSERT_IMP(a_no_load_busy, i_clk, i_rst_n, w_cmd.load_wr, !w_cmd.bf_rd && !w_busy)
    `R2F_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
endmodule
